// ----- sv/nmb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmb_pkg
// shared widths, codes and pipeline types for the montgomery butterfly
// ----------------------------------------------------------------------------
package nmb_pkg;

  localparam int unsigned COEF_W = 32;
  localparam int unsigned MOD_W  = 31;
  localparam int unsigned PROD_W = 2 * COEF_W;
  localparam int unsigned CFG_W  = 32;

  // latency of the reduction pipeline
  localparam int unsigned MONT_LAT = 4;

  typedef enum logic [1:0] {
    OP_FWD   = 2'd0,
    OP_INV   = 2'd1,
    OP_SCALE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_MODULUS   = 2'd0,
    CFG_Q_INVERSE = 2'd1,
    CFG_SCALE     = 2'd2
  } cfg_idx_t;

  // side band that travels alongside the reduction
  typedef struct packed {
    op_t                      op;
    logic signed [COEF_W-1:0] u;
    logic signed [COEF_W-1:0] sum;
  } side_t;

endpackage

// ----- sv/ntt_montgomery_butterfly.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt_montgomery_butterfly
// pipelined ntt butterfly with montgomery reduction (forward, inverse, scale)
// ----------------------------------------------------------------------------
//
// channel   | handshake          | payload
// ----------+--------------------+-----------------------------------------
// command   | start / busy       | opcode, u_coef, v_coef, twiddle
// result    | done (strobe)      | first_result, second_result
// config    | cfg_write          | cfg_index, cfg_data
//
// one transaction enters per clock; busy is never raised
// each result passes through the input stage, the multiplier, four reduction
// stages (qinv multiply, q multiply, wide subtract, correction) and the output
// adder stage, in that order
// rst is synchronous; it clears the valid bits, q_inverse and final_scale and
// sets modulus to 12289; the receiver cannot stall, so there is no back-pressure anywhere
// ----------------------------------------------------------------------------
module ntt_montgomery_butterfly
  import nmb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // command
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic signed [COEF_W-1:0] u_coef,
  input  logic signed [COEF_W-1:0] v_coef,
  input  logic signed [COEF_W-1:0] twiddle,
  // result
  output logic                     done,
  output logic signed [COEF_W-1:0] first_result,
  output logic signed [COEF_W-1:0] second_result,
  // configuration
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  // configuration registers
  logic [MOD_W-1:0]  modulus;
  logic [COEF_W-1:0] q_inverse;
  logic [MOD_W-1:0]  final_scale;

  // input stage operands
  op_t                      op_in;
  logic signed [COEF_W-1:0] a_in, b_in, sum_in;

  // stage 1
  logic                     valid1;
  side_t                    side1;
  logic signed [COEF_W-1:0] a1, b1;

  // stage 2
  logic                     valid2;
  side_t                    side2;
  logic signed [PROD_W-1:0] prod2;

  // reduction and side band delay line
  logic                     mont_valid;
  logic [COEF_W-1:0]        mont_res;
  side_t                    side_d [MONT_LAT];

  // output stage
  logic [COEF_W-1:0]        first_next, second_next;
  logic [COEF_W-1:0]        q_ext;

  assign busy  = 1'b0;
  assign q_ext = {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= MOD_W'(12289);
      q_inverse   <= '0;
      final_scale <= '0;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODULUS:   modulus     <= cfg_data[MOD_W-1:0];
        CFG_Q_INVERSE: q_inverse   <= cfg_data[COEF_W-1:0];
        CFG_SCALE:     final_scale <= cfg_data[MOD_W-1:0];
        default: ;
      endcase
    end
  end

  // operand selection: forward reduces v*w, inverse (u-v)*w, scale u*s
  always_comb begin
    op_in  = op_t'(opcode);
    sum_in = u_coef + v_coef - $signed(q_ext);
    case (op_in)
      OP_INV: begin
        a_in = u_coef - v_coef;
        b_in = twiddle;
      end
      OP_SCALE: begin
        a_in = u_coef;
        b_in = $signed({1'b0, final_scale});
      end
      default: begin
        a_in = v_coef;
        b_in = twiddle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid1 <= start && !busy;
      valid2 <= valid1;
      done   <= mont_valid;
    end
  end

  always_ff @(posedge clk) begin
    side1.op  <= op_in;
    side1.u   <= u_coef;
    side1.sum <= sum_in;
    a1        <= a_in;
    b1        <= b_in;

    // full signed product; inverse sum brought back to nonnegative
    prod2    <= a1 * b1;
    side2.op <= side1.op;
    side2.u  <= side1.u;
    if (side1.sum[COEF_W-1]) begin
      side2.sum <= side1.sum + $signed(q_ext);
    end else begin
      side2.sum <= side1.sum;
    end

    side_d[0] <= side2;
    for (int i = 1; i < MONT_LAT; i++) begin
      side_d[i] <= side_d[i-1];
    end

    first_result  <= first_next;
    second_result <= second_next;
  end

  nmb_mont_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid2),
    .prod      (prod2),
    .modulus   (modulus),
    .q_inverse (q_inverse),
    .out_valid (mont_valid),
    .result    (mont_res)
  );

  // final butterfly arithmetic, all wrapping to 32 bits
  always_comb begin
    case (side_d[MONT_LAT-1].op)
      OP_FWD: begin
        // no final correction in the forward direction
        first_next  = side_d[MONT_LAT-1].u + mont_res - q_ext;
        second_next = side_d[MONT_LAT-1].u - mont_res;
      end
      OP_INV: begin
        first_next  = side_d[MONT_LAT-1].sum;
        second_next = mont_res;
      end
      OP_SCALE: begin
        first_next  = mont_res;
        second_next = '0;
      end
      default: begin
        first_next  = '0;
        second_next = '0;
      end
    endcase
  end

endmodule

// ----- sv/nmb_mont_reduce.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmb_mont_reduce
// four-stage montgomery reduction of a signed 64-bit product, beta = 2^32
// ----------------------------------------------------------------------------
module nmb_mont_reduce
  import nmb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [PROD_W-1:0]  prod,
  input  logic [MOD_W-1:0]          modulus,
  input  logic [COEF_W-1:0]         q_inverse,
  output logic                      out_valid,
  output logic [COEF_W-1:0]         result
);

  logic [COEF_W-1:0]           m_low;
  logic [COEF_W+MOD_W-1:0]     t_full;
  logic signed [PROD_W:0]      diff_full;
  logic signed [COEF_W:0]      r_hi;

  logic                        valid_a, valid_b, valid_c;
  logic signed [PROD_W-1:0]    prod_a, prod_b;
  logic [COEF_W-1:0]           m_a;
  logic [COEF_W+MOD_W-1:0]     t_b;
  logic signed [PROD_W:0]      diff_c;

  // m = low half of p * qinv
  assign m_low = COEF_W'(prod[COEF_W-1:0] * q_inverse);
  // t = m * q, below 2^63
  assign t_full = (COEF_W+MOD_W)'(m_a) * (COEF_W+MOD_W)'(modulus);
  // exact p - t
  assign diff_full = $signed({prod_b[PROD_W-1], prod_b})
                   - $signed({2'b00, t_b});
  assign r_hi = diff_c[PROD_W:COEF_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      valid_c   <= valid_b;
      out_valid <= valid_c;
    end
  end

  always_ff @(posedge clk) begin
    prod_a <= prod;
    m_a    <= m_low;
    prod_b <= prod_a;
    t_b    <= t_full;
    diff_c <= diff_full;
    // add q back when the quotient came out negative
    if (r_hi[COEF_W]) begin
      result <= r_hi[COEF_W-1:0] + {1'b0, modulus};
    end else begin
      result <= r_hi[COEF_W-1:0];
    end
  end

endmodule
